>>> rtl/core/tosd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosd_pkg - shared types and constants for the 3-of-6 stream decoder
// Holds the weight-3 code table, the lookup function, the status codes and
// the result and push structures passed between the decoder and its queue.
// ----------------------------------------------------------------------------
package tosd_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CODE = 2'd1,
        ST_LIMIT    = 2'd2
    } status_t;

    // One result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        status_t    status;
        logic       last;
    } result_t;

    // Results produced by one decoded input beat (zero, one or two)
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    localparam int WORD_W     = 6;
    localparam int NIB_W      = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    // Weight-3 codes in ascending order, index = nibble
    localparam logic [WORD_W-1:0] CODE_TABLE [16] = '{
        6'h07, 6'h0B, 6'h0D, 6'h0E, 6'h13, 6'h15, 6'h16, 6'h19,
        6'h1A, 6'h1C, 6'h23, 6'h25, 6'h26, 6'h29, 6'h2A, 6'h2C
    };

    localparam result_t RESULT_ZERO = '{
        out_byte: 8'h00, byte_valid: 1'b0, status: ST_OK, last: 1'b0
    };

    // Returns {miss, nibble}; miss set when the word is not a table code
    function automatic logic [NIB_W:0] lookup_word(input logic [WORD_W-1:0] word);
        logic [NIB_W:0] res;
        res = {1'b1, {NIB_W{1'b0}}};
        for (int k = 0; k < 16; k++)
        begin
            if (CODE_TABLE[k] == word)
            begin
                res = {1'b0, NIB_W'(k)};
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/core/tosd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosd_core - input register, bit gearbox and word decode
// Registers the incoming beat, appends its bits to the leftover bits, splits
// off one or two 6-bit words, looks them up and pairs nibbles into bytes.
// Produces up to two results per beat and keeps the per-frame state.
// ----------------------------------------------------------------------------
module tosd_core #(
    parameter int MAX_NIBBLES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              room,
    output tosd_pkg::push_t   push
);

    localparam int SEEN_W = $clog2(MAX_NIBBLES + 1);

    // Input register
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic                 step;

    // Frame state
    logic [3:0]           leftover_bits_reg, leftover_bits_next;
    logic [2:0]           leftover_count_reg, leftover_count_next;
    logic [3:0]           held_nibble_reg, held_nibble_next;
    logic                 held_valid_reg, held_valid_next;
    logic [SEEN_W-1:0]    seen_reg, seen_next;
    logic                 frame_failed_reg, frame_failed_next;

    // Decode working values
    logic [11:0]          bits_w;
    logic [5:0]           words [2];
    logic                 two_words;
    logic [4:0]           look;
    logic                 held_v;
    logic [3:0]           held_n;
    logic [SEEN_W-1:0]    seen_v;
    logic                 failed;
    logic [1:0]           n_res;
    logic                 cand_en;
    tosd_pkg::result_t    cand;
    tosd_pkg::result_t    res0, res1;

    assign step     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || room;

    // Input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    // Gearbox: leftover bits first, new byte above them
    always_comb
    begin
        case (leftover_count_reg)
            3'd2:    bits_w = {2'b00, in_byte_reg, leftover_bits_reg[1:0]};
            3'd4:    bits_w = {in_byte_reg, leftover_bits_reg};
            default: bits_w = {4'b0000, in_byte_reg};
        endcase
    end

    assign words[0]  = bits_w[5:0];
    assign words[1]  = bits_w[11:6];
    assign two_words = (leftover_count_reg == 3'd4);

    // Word decode, nibble pairing and frame-end handling
    always_comb
    begin
        held_v  = held_valid_reg;
        held_n  = held_nibble_reg;
        seen_v  = seen_reg;
        failed  = 1'b0;
        n_res   = 2'd0;
        res0    = tosd_pkg::RESULT_ZERO;
        res1    = tosd_pkg::RESULT_ZERO;
        look    = '0;
        cand    = tosd_pkg::RESULT_ZERO;
        cand_en = 1'b0;

        for (int k = 0; k < 2; k++)
        begin
            if ((k == 0 || two_words) && !failed)
            begin
                look    = tosd_pkg::lookup_word(words[k]);
                cand    = tosd_pkg::RESULT_ZERO;
                cand_en = 1'b0;
                if (look[4])
                begin
                    cand.status = tosd_pkg::ST_BAD_CODE;
                    cand.last   = 1'b1;
                    cand_en     = 1'b1;
                    failed      = 1'b1;
                end
                else if (seen_v >= SEEN_W'(MAX_NIBBLES))
                begin
                    cand.status = tosd_pkg::ST_LIMIT;
                    cand.last   = 1'b1;
                    cand_en     = 1'b1;
                    failed      = 1'b1;
                end
                else
                begin
                    seen_v = seen_v + 1'b1;
                    if (held_v)
                    begin
                        cand.out_byte   = {look[3:0], held_n};
                        cand.byte_valid = 1'b1;
                        cand_en         = 1'b1;
                        held_v          = 1'b0;
                        held_n          = 4'h0;
                    end
                    else
                    begin
                        held_n = look[3:0];
                        held_v = 1'b1;
                    end
                end
                if (cand_en)
                begin
                    if (n_res == 2'd0)
                    begin
                        res0 = cand;
                    end
                    else
                    begin
                        res1 = cand;
                    end
                    n_res = n_res + 2'd1;
                end
            end
        end

        leftover_bits_next  = leftover_bits_reg;
        leftover_count_next = leftover_count_reg;
        held_nibble_next    = held_nibble_reg;
        held_valid_next     = held_valid_reg;
        seen_next           = seen_reg;
        frame_failed_next   = frame_failed_reg;

        if (frame_failed_reg)
        begin
            // Discarding the rest of a failed frame; its end clears everything
            n_res = 2'd0;
            if (in_last_reg)
            begin
                leftover_bits_next  = 4'h0;
                leftover_count_next = 3'd0;
                held_nibble_next    = 4'h0;
                held_valid_next     = 1'b0;
                seen_next           = '0;
                frame_failed_next   = 1'b0;
            end
        end
        else if (failed)
        begin
            held_nibble_next = held_n;
            held_valid_next  = held_v;
            seen_next        = seen_v;
            if (in_last_reg)
            begin
                leftover_bits_next  = 4'h0;
                leftover_count_next = 3'd0;
                held_nibble_next    = 4'h0;
                held_valid_next     = 1'b0;
                seen_next           = '0;
            end
            else
            begin
                frame_failed_next = 1'b1;
            end
        end
        else
        begin
            held_nibble_next = held_n;
            held_valid_next  = held_v;
            seen_next        = seen_v;
            case (leftover_count_reg)
                3'd2:
                begin
                    leftover_bits_next  = bits_w[9:6];
                    leftover_count_next = 3'd4;
                end
                3'd4:
                begin
                    leftover_bits_next  = 4'h0;
                    leftover_count_next = 3'd0;
                end
                default:
                begin
                    leftover_bits_next  = {2'b00, bits_w[7:6]};
                    leftover_count_next = 3'd2;
                end
            endcase

            if (in_last_reg)
            begin
                // Odd nibble goes out alone, otherwise a bare end if nothing went out
                cand = tosd_pkg::RESULT_ZERO;
                if (held_v)
                begin
                    cand.out_byte   = {4'h0, held_n};
                    cand.byte_valid = 1'b1;
                end
                if (held_v || n_res == 2'd0)
                begin
                    if (n_res == 2'd0)
                    begin
                        res0 = cand;
                    end
                    else
                    begin
                        res1 = cand;
                    end
                    n_res = n_res + 2'd1;
                end
                if (n_res == 2'd2)
                begin
                    res1.last = 1'b1;
                end
                else
                begin
                    res0.last = 1'b1;
                end
                leftover_bits_next  = 4'h0;
                leftover_count_next = 3'd0;
                held_nibble_next    = 4'h0;
                held_valid_next     = 1'b0;
                seen_next           = '0;
            end
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_bits_reg  <= 4'h0;
            leftover_count_reg <= 3'd0;
            held_nibble_reg    <= 4'h0;
            held_valid_reg     <= 1'b0;
            seen_reg           <= '0;
            frame_failed_reg   <= 1'b0;
        end
        else if (step)
        begin
            leftover_bits_reg  <= leftover_bits_next;
            leftover_count_reg <= leftover_count_next;
            held_nibble_reg    <= held_nibble_next;
            held_valid_reg     <= held_valid_next;
            seen_reg           <= seen_next;
            frame_failed_reg   <= frame_failed_next;
        end
    end

    assign push.cnt = step ? n_res : 2'd0;
    assign push.r0  = res0;
    assign push.r1  = res1;

endmodule

>>> rtl/core/tosd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosd_fifo - four-entry result queue
// Takes up to two results per cycle from the decoder, hands out one beat
// per cycle while out_ready is high, flags room with two or more slots free.
// ----------------------------------------------------------------------------
module tosd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  tosd_pkg::push_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output tosd_pkg::result_t out_data
);

    tosd_pkg::result_t                 entry_reg [tosd_pkg::FIFO_DEPTH];
    logic [tosd_pkg::PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [tosd_pkg::PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [tosd_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                              pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= tosd_pkg::CNT_W'(tosd_pkg::FIFO_DEPTH - 2));

    // Pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + tosd_pkg::PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + tosd_pkg::PTR_W'(pop);
        count_next  = count_reg + tosd_pkg::CNT_W'(push.cnt) - tosd_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry writes, first result at the write pointer, second just after
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            entry_reg[wr_ptr_reg + 1'b1] <= push.r1;
        end
    end

    // Never pushes past the depth
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |->
        (({1'b0, count_reg} + 4'(push.cnt)) <= 4'(tosd_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

    // Fill count agrees with the pointers
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[tosd_pkg::PTR_W-1:0] == (wr_ptr_reg - rd_ptr_reg))
        else $error("fill count and pointers disagree");

    // A push always leaves the queue non-empty afterwards
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |=> (count_reg != '0))
        else $error("pushed result went missing");

endmodule

>>> rtl/core/three_of_six_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_of_six_stream_decoder_top - 3-of-6 line decoder for frame bytes
// Decodes LSB-first 6-bit weight-3 words into nibbles and pairs them into
// bytes, with frame-end, odd-nibble, invalid-code and length-limit handling.
//
//   channel   dir  tdata               tuser                     tlast
//   s_axis    in   enc_byte[7:0]       -                         frame_end
//   m_axis    out  out_byte[7:0]       byte_valid, status[1:0]   last
//
// One input beat per cycle while the queue has room; each beat yields zero,
// one or two result beats. The path is the input register, then decode into a
// four-entry result queue whose head drives m_axis. The output side moves one
// beat per cycle while m_axis_tready is high, so s_axis_tready drops while a
// beat is held in the input register and the queue holds over two results.
// Reset clears all frame state and the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module three_of_six_stream_decoder_top #(
    parameter int MAX_NIBBLES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] enc_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [0] byte_valid, [2:1] status
    output logic       m_axis_tlast
);

    tosd_pkg::push_t   push;
    tosd_pkg::result_t head;
    logic              room;

    // Gearbox and decode
    tosd_core #(
        .MAX_NIBBLES (MAX_NIBBLES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .room     (room),
        .push     (push)
    );

    // Result queue
    tosd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    assign m_axis_tdata = head.out_byte;
    assign m_axis_tuser = {head.status, head.byte_valid};
    assign m_axis_tlast = head.last;

endmodule
